// ----- hdl/crc16_frame_receiver_macros.svh -----
// ----------------------------------------------------------------------------
// CRC-16 frame receiver assertion macros
// Shared assertion forms for the modules of the frame receiver.
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_RECEIVER_MACROS_SVH
`define CRC16_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CFR_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CFR_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// CRC-16 frame receiver package
// Types, event codes, reset values and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int WRITE_PAYLOAD_BYTES_DEF = 256;
  localparam int PAYLOAD_DEPTH_DEF       = 256;

  localparam logic [7:0]  WRITE_CMD_RST  = 8'h0A;
  localparam logic [7:0]  MIN_LEN_RST    = 8'd3;
  localparam logic [7:0]  MAX_LEN_RST    = 8'd255;
  localparam logic [7:0]  HDR_BYTES      = 8'd3;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL  = 16'hA001;

  localparam logic [1:0] CFG_WRITE_CMD = 2'd0;
  localparam logic [1:0] CFG_MIN_LEN   = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN   = 2'd2;

  localparam logic [2:0] EV_WRITE_START = 3'd0;
  localparam logic [2:0] EV_BAD_LENGTH  = 3'd1;
  localparam logic [2:0] EV_FRAME_START = 3'd2;
  localparam logic [2:0] EV_CRC_OK      = 3'd3;
  localparam logic [2:0] EV_CRC_FAIL    = 3'd4;
  localparam logic [2:0] EV_WRITE_OK    = 3'd5;
  localparam logic [2:0] EV_WRITE_FAIL  = 3'd6;
  localparam logic [2:0] EV_READ        = 3'd7;

  typedef struct packed {
    logic [7:0] write_cmd;
    logic [7:0] min_len;
    logic [7:0] max_len;
  } cfr_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] ev;
    logic [7:0] command;
    logic [8:0] length;
  } cfr_result_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } cfr_wr_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/cfr_payload_ram.sv -----
// ----------------------------------------------------------------------------
// CRC-16 frame receiver payload memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module cfr_payload_ram #(
  parameter int DEPTH = cfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic             clk,
  input  cfr_pkg::cfr_wr_t wr,
  input  logic             rd_en,
  input  logic [7:0]       rd_addr,
  output logic [7:0]       rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[AW'(wr.addr)] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[AW'(rd_addr)];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/cfr_parser.sv -----
// ----------------------------------------------------------------------------
// CRC-16 frame receiver parser
// Frame state machine with per-byte CRC update and payload store writes.
// ----------------------------------------------------------------------------
`include "crc16_frame_receiver_macros.svh"

module cfr_parser #(
  parameter int WRITE_PAYLOAD_BYTES = cfr_pkg::WRITE_PAYLOAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfr_pkg::cfr_cfg_t    cfg,
  input  logic                 accept,
  input  logic                 mode,
  input  logic [7:0]           rx_byte,
  output cfr_pkg::cfr_result_t res,
  output cfr_pkg::cfr_wr_t     wr
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FRAME = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;

  localparam logic [8:0] WPB_LEN = 9'(WRITE_PAYLOAD_BYTES);

  logic [1:0]  phase_r, phase_nxt;
  logic [8:0]  count_r, count_nxt;
  logic [7:0]  target_r, target_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  cmd_r, cmd_nxt;

  logic [9:0]  pos_p2;
  logic [8:0]  pos_m1;
  logic        crc_match;
  logic [15:0] crc_upd;
  logic        bad_len;

  assign pos_p2    = {1'b0, count_r} + 10'd2;
  assign pos_m1    = count_r - 9'd1;
  assign crc_match = ({rx_byte, low_r} == crc_r);
  assign crc_upd   = cfr_pkg::crc_update(crc_r, rx_byte);
  assign bad_len   = (rx_byte < cfr_pkg::HDR_BYTES) || (rx_byte < cfg.min_len) ||
                     (rx_byte > cfg.max_len);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    target_nxt = target_r;
    crc_nxt    = crc_r;
    low_nxt    = low_r;
    cmd_nxt    = cmd_r;
    res        = '0;
    wr         = '0;
    wr.data    = rx_byte;
    if (accept) begin
      if (mode) begin
        res.valid = 1'b1;
        res.ev    = cfr_pkg::EV_READ;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            res.valid = 1'b1;
            if (rx_byte == cfg.write_cmd) begin
              phase_nxt   = PH_WRITE;
              count_nxt   = '0;
              cmd_nxt     = rx_byte;
              crc_nxt     = cfr_pkg::crc_update(cfr_pkg::CRC_INIT, rx_byte);
              res.ev      = cfr_pkg::EV_WRITE_START;
              res.command = rx_byte;
              res.length  = WPB_LEN;
            end else if (bad_len) begin
              res.ev = cfr_pkg::EV_BAD_LENGTH;
            end else begin
              phase_nxt  = PH_FRAME;
              target_nxt = rx_byte;
              count_nxt  = '0;
              crc_nxt    = cfr_pkg::CRC_INIT;
              res.ev     = cfr_pkg::EV_FRAME_START;
              res.length = {1'b0, rx_byte - cfr_pkg::HDR_BYTES};
            end
          end
          PH_FRAME: begin
            count_nxt = count_r + 9'd1;
            if (count_r == 9'd0) begin
              cmd_nxt = rx_byte;
              crc_nxt = crc_upd;
            end else if (pos_p2 < {2'b00, target_r}) begin
              wr.en   = 1'b1;
              wr.addr = pos_m1[7:0];
              crc_nxt = crc_upd;
            end else if (pos_p2 == {2'b00, target_r}) begin
              low_nxt = rx_byte;
            end else begin
              phase_nxt   = PH_IDLE;
              count_nxt   = '0;
              res.valid   = 1'b1;
              res.ev      = crc_match ? cfr_pkg::EV_CRC_OK : cfr_pkg::EV_CRC_FAIL;
              res.command = cmd_r;
              res.length  = {1'b0, target_r - cfr_pkg::HDR_BYTES};
            end
          end
          PH_WRITE: begin
            count_nxt = count_r + 9'd1;
            if (count_r < WPB_LEN) begin
              wr.en   = 1'b1;
              wr.addr = count_r[7:0];
              crc_nxt = crc_upd;
            end else if (count_r == WPB_LEN) begin
              low_nxt = rx_byte;
            end else begin
              phase_nxt   = PH_IDLE;
              count_nxt   = '0;
              res.valid   = 1'b1;
              res.ev      = crc_match ? cfr_pkg::EV_WRITE_OK : cfr_pkg::EV_WRITE_FAIL;
              res.command = cmd_r;
              res.length  = WPB_LEN;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            count_nxt = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      count_r  <= '0;
      target_r <= '0;
      crc_r    <= cfr_pkg::CRC_INIT;
      low_r    <= '0;
      cmd_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      target_r <= target_nxt;
      crc_r    <= crc_nxt;
      low_r    <= low_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

  `CFR_ASSERT_IMP(a_idle_byte_reports, clk, rst_n, accept && !mode && phase_r == PH_IDLE, res.valid, "Idle byte gave no result")
  `CFR_ASSERT_IMP(a_store_in_frame, clk, rst_n, wr.en, phase_r == PH_FRAME || phase_r == PH_WRITE, "Payload write outside a frame")
  `CFR_ASSERT_NXT(a_end_to_idle, clk, rst_n, res.valid && res.ev != cfr_pkg::EV_READ && phase_r != PH_IDLE, phase_r == PH_IDLE && count_r == 9'd0, "Parser did not return to idle")

endmodule

// ----- hdl/crc16_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// CRC-16 frame receiver
// Length-prefixed and fixed-size write frame parser with CRC-16/MODBUS check.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle while no held result is stalled.
// Its result, if any, is held in the output register from the cycle after
// the transfer, and the next item is accepted in the same cycle as that result
// is taken. Read data comes from the registered read port of the payload
// memory, which is written by the parser in the same cycle as a data byte is
// taken, so a read may follow a write directly. The memory has no clearing
// pass; an entry that was never written reads as unknown data.
`include "crc16_frame_receiver_macros.svh"

module crc16_frame_receiver #(
  parameter int WRITE_PAYLOAD_BYTES = cfr_pkg::WRITE_PAYLOAD_BYTES_DEF,
  parameter int PAYLOAD_DEPTH       = cfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte [7:0], read_index [15:8]
  input  logic        in_tuser,   // mode [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // command [7:0], payload_length [16:8], read_data [24:17]
  output logic [2:0]  out_tuser   // event_res [2:0]
);

  cfr_pkg::cfr_cfg_t    cfg_r;
  cfr_pkg::cfr_result_t res;
  cfr_pkg::cfr_wr_t     wr;

  logic       accept;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] ev_r;
  logic [7:0] cmd_r;
  logic [8:0] len_r;
  logic [7:0] ram_rdata;
  logic [7:0] read_data;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.write_cmd <= cfr_pkg::WRITE_CMD_RST;
      cfg_r.min_len   <= cfr_pkg::MIN_LEN_RST;
      cfg_r.max_len   <= cfr_pkg::MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        cfr_pkg::CFG_WRITE_CMD: cfg_r.write_cmd <= cfg_wdata;
        cfr_pkg::CFG_MIN_LEN:   cfg_r.min_len   <= cfg_wdata;
        cfr_pkg::CFG_MAX_LEN:   cfg_r.max_len   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cfr_parser #(
    .WRITE_PAYLOAD_BYTES(WRITE_PAYLOAD_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .mode    (in_tuser),
    .rx_byte (in_tdata[7:0]),
    .res     (res),
    .wr      (wr)
  );

  cfr_payload_ram #(
    .DEPTH(PAYLOAD_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept && in_tuser),
    .rd_addr (in_tdata[15:8]),
    .rd_data (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_r  <= res.ev;
      cmd_r <= res.command;
      len_r <= res.length;
    end
  end

  assign read_data  = (ev_r == cfr_pkg::EV_READ) ? ram_rdata : 8'h00;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = ev_r;
  assign out_tdata  = {7'b0, read_data, len_r, cmd_r};

  `CFR_ASSERT_NXT(a_read_result, clk, rst_n, in_tvalid && in_tready && in_tuser, out_tvalid && out_tuser == cfr_pkg::EV_READ, "Read transfer gave no read result")
  `CFR_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, !in_tready, out_tvalid && !out_tready, "Input held off without an output stall")

endmodule
